/* hdl/dcd_pkg.sv */
// Shared types and constants for the double clap detector.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package dcd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int LEVEL_W   = 17;
  localparam int ELAPSED_W = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // reset values of the settings registers
  localparam logic [CFG_W-1:0] LOUD_THRESHOLD_RST = 16'd200;
  localparam logic [CFG_W-1:0] QUIET_LEVEL_RST    = 16'd30;
  localparam logic [CFG_W-1:0] MIN_LOUD_MS_RST    = 16'd20;
  localparam logic [CFG_W-1:0] PAUSE_MS_RST       = 16'd60;
  localparam logic [CFG_W-1:0] WINDOW_MS_RST      = 16'd200;

  typedef enum logic [1:0] {
    OP_CALIB   = 2'd0,
    OP_MEASURE = 2'd1,
    OP_TICK    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_FIRST      = 2'd0,
    PH_WAIT_QUIET = 2'd1,
    PH_PAUSE      = 2'd2,
    PH_SECOND     = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOUD_THRESHOLD = 3'd0,
    REG_QUIET_LEVEL    = 3'd1,
    REG_MIN_LOUD_MS    = 3'd2,
    REG_PAUSE_MS       = 3'd3,
    REG_WINDOW_MS      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] loud_threshold;
    logic [CFG_W-1:0] quiet_level;
    logic [CFG_W-1:0] min_loud_ms;
    logic [CFG_W-1:0] pause_ms;
    logic [CFG_W-1:0] window_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
  } item_t;

  typedef struct packed {
    logic               double_clap;
    phase_t             phase;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

/* hdl/dcd_channels.sv */
// Valid/ready channel interfaces: input items, results and settings writes.
// Depends on dcd_pkg for field widths.
interface dcd_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [dcd_pkg::SAMPLE_W-1:0] sample_a;
  logic [dcd_pkg::SAMPLE_W-1:0] sample_b;
  logic [dcd_pkg::SAMPLE_W-1:0] sample_c;
  logic [dcd_pkg::SAMPLE_W-1:0] sample_d;

  modport source (output valid, operation, sample_a, sample_b, sample_c, sample_d,
                  input ready);
  modport sink   (input valid, operation, sample_a, sample_b, sample_c, sample_d,
                  output ready);
endinterface

interface dcd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        double_clap;
  logic [1:0]                  phase;
  logic [dcd_pkg::LEVEL_W-1:0] level;

  modport source (output valid, double_clap, phase, level, input ready);
  modport sink   (input valid, double_clap, phase, level, output ready);
endinterface

interface dcd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dcd_pkg::CFG_IDX_W-1:0] index;
  logic [dcd_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dcd_cfg_regs.sv */
// Settings register file: thresholds and timing limits.
// Depends on dcd_pkg and dcd_cfg_if.
module dcd_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  dcd_cfg_if.sink          cfg,
  output dcd_pkg::cfg_t    regs
);

  dcd_pkg::cfg_t regs_r;
  dcd_pkg::cfg_t regs_nxt;

  assign cfg.ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      case (dcd_pkg::cfg_reg_t'(cfg.index))
        dcd_pkg::REG_LOUD_THRESHOLD: regs_nxt.loud_threshold = cfg.data;
        dcd_pkg::REG_QUIET_LEVEL:    regs_nxt.quiet_level    = cfg.data;
        dcd_pkg::REG_MIN_LOUD_MS:    regs_nxt.min_loud_ms    = cfg.data;
        dcd_pkg::REG_PAUSE_MS:       regs_nxt.pause_ms       = cfg.data;
        dcd_pkg::REG_WINDOW_MS:      regs_nxt.window_ms      = cfg.data;
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.loud_threshold <= dcd_pkg::LOUD_THRESHOLD_RST;
      regs_r.quiet_level    <= dcd_pkg::QUIET_LEVEL_RST;
      regs_r.min_loud_ms    <= dcd_pkg::MIN_LOUD_MS_RST;
      regs_r.pause_ms       <= dcd_pkg::PAUSE_MS_RST;
      regs_r.window_ms      <= dcd_pkg::WINDOW_MS_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

/* hdl/dcd_calib.sv */
// Noise floor calibration: accumulates calibration samples and loads the
// floor as their mean. Depends on dcd_pkg.
module dcd_calib #(
  parameter int CALIB_SAMPLES = 10,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  dcd_pkg::item_t         item,
  output logic [SAMPLE_BITS-1:0] noise_floor
);

  localparam int SUM_W   = SAMPLE_BITS + 4;
  localparam int CNT_W   = $clog2(CALIB_SAMPLES + 1);
  // mean by reciprocal multiply: exact for every SUM_W-bit sum
  localparam int SHIFT   = SUM_W + $clog2(CALIB_SAMPLES);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  logic [SUM_W-1:0]       calib_sum_r,   calib_sum_nxt;
  logic [CNT_W-1:0]       calib_count_r, calib_count_nxt;
  logic [SAMPLE_BITS-1:0] noise_floor_r, noise_floor_nxt;

  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  count_inc;
  logic [PROD_W-1:0] product;

  assign sum_acc   = calib_sum_r + SUM_W'(item.sample_a[SAMPLE_BITS-1:0]);
  assign count_inc = calib_count_r + CNT_W'(1);
  assign product   = PROD_W'(sum_acc) * PROD_W'(RECIP);

  always_comb begin
    calib_sum_nxt   = calib_sum_r;
    calib_count_nxt = calib_count_r;
    noise_floor_nxt = noise_floor_r;
    if (fire && (dcd_pkg::op_t'(item.operation) == dcd_pkg::OP_CALIB)) begin
      if (count_inc == CNT_W'(CALIB_SAMPLES)) begin
        noise_floor_nxt = product[SHIFT +: SAMPLE_BITS];
        calib_sum_nxt   = '0;
        calib_count_nxt = '0;
      end else begin
        calib_sum_nxt   = sum_acc;
        calib_count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_sum_r   <= '0;
      calib_count_r <= '0;
      noise_floor_r <= '0;
    end else begin
      calib_sum_r   <= calib_sum_nxt;
      calib_count_r <= calib_count_nxt;
      noise_floor_r <= noise_floor_nxt;
    end
  end

  assign noise_floor = noise_floor_r;

endmodule

/* hdl/dcd_detect.sv */
// Level measurement, millisecond timer and the four-phase clap state machine.
// Depends on dcd_pkg.
module dcd_detect #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  dcd_pkg::item_t         item,
  input  dcd_pkg::cfg_t          cfg,
  input  logic [SAMPLE_BITS-1:0] noise_floor,
  output dcd_pkg::result_t       result
);

  localparam int LW = dcd_pkg::LEVEL_W;

  dcd_pkg::phase_t                 phase_r,      phase_nxt;
  logic [dcd_pkg::ELAPSED_W-1:0]   elapsed_r,    elapsed_nxt;
  logic [LW-1:0]                   last_level_r, last_level_nxt;

  logic [SAMPLE_BITS+1:0] quad_sum;
  logic [LW-1:0]          lvl_meas;
  logic [LW-1:0]          mag;
  logic                   loud_mag;
  logic                   quiet_mag;
  logic                   loud_signed;
  logic                   clap;

  assign quad_sum = (SAMPLE_BITS+2)'(item.sample_a[SAMPLE_BITS-1:0])
                  + (SAMPLE_BITS+2)'(item.sample_b[SAMPLE_BITS-1:0])
                  + (SAMPLE_BITS+2)'(item.sample_c[SAMPLE_BITS-1:0])
                  + (SAMPLE_BITS+2)'(item.sample_d[SAMPLE_BITS-1:0]);
  assign lvl_meas = LW'(quad_sum[SAMPLE_BITS+1:2]) - LW'(noise_floor);
  assign mag      = lvl_meas[LW-1] ? (~lvl_meas + LW'(1)) : lvl_meas;

  assign loud_mag    = mag > LW'(cfg.loud_threshold);
  assign quiet_mag   = mag < LW'(cfg.quiet_level);
  // pause phase compares the signed level, not its magnitude
  assign loud_signed = $signed(lvl_meas) > $signed(LW'(cfg.loud_threshold));

  always_comb begin
    phase_nxt      = phase_r;
    elapsed_nxt    = elapsed_r;
    last_level_nxt = last_level_r;
    clap           = 1'b0;
    if (fire) begin
      case (dcd_pkg::op_t'(item.operation))
        dcd_pkg::OP_MEASURE: begin
          last_level_nxt = lvl_meas;
          case (phase_r)
            dcd_pkg::PH_FIRST: begin
              if (loud_mag) begin
                phase_nxt   = dcd_pkg::PH_WAIT_QUIET;
                elapsed_nxt = '0;
              end
            end
            dcd_pkg::PH_WAIT_QUIET: begin
              if (quiet_mag && (elapsed_r > cfg.min_loud_ms)) begin
                phase_nxt   = dcd_pkg::PH_PAUSE;
                elapsed_nxt = '0;
              end
            end
            dcd_pkg::PH_PAUSE: begin
              if (loud_signed) begin
                phase_nxt = dcd_pkg::PH_FIRST;
              end else if (elapsed_r > cfg.pause_ms) begin
                phase_nxt   = dcd_pkg::PH_SECOND;
                elapsed_nxt = '0;
              end
            end
            default: begin
              if (loud_mag) begin
                clap      = 1'b1;
                phase_nxt = dcd_pkg::PH_FIRST;
              end else if (elapsed_r > cfg.window_ms) begin
                phase_nxt = dcd_pkg::PH_FIRST;
              end
            end
          endcase
        end
        dcd_pkg::OP_TICK: begin
          if (elapsed_r != dcd_pkg::ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + dcd_pkg::ELAPSED_W'(1);
          end
        end
        default: ; // calibration handled elsewhere; unused code is a no-op
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= dcd_pkg::PH_FIRST;
      elapsed_r    <= '0;
      last_level_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      elapsed_r    <= elapsed_nxt;
      last_level_r <= last_level_nxt;
    end
  end

  assign result.double_clap = clap;
  assign result.phase       = phase_nxt;
  assign result.level       = last_level_nxt;

endmodule

/* hdl/double_clap_detector_core.sv */
// Double clap detector top level: input register, step logic, result register.
// Throughput: one beat per cycle unless out_ch stalls; a beat waits in the input
// register and its result in the result register, and the step logic (4-sample add
// and compare, or calibration add and one reciprocal multiply) sits between them.
// Reset (rst_n low, synchronous): both registers empty, phase first, timer,
// calibration and level cleared, noise floor 0, settings at their defaults.
module double_clap_detector_core #(
  parameter int CALIB_SAMPLES = 10,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  dcd_in_if.sink     in_ch,
  dcd_out_if.source  out_ch,
  dcd_cfg_if.sink    cfg_ch
);

  logic                  in_valid_r,  in_valid_nxt;
  dcd_pkg::item_t        in_item_r;
  logic                  out_valid_r, out_valid_nxt;
  dcd_pkg::result_t      out_res_r;

  logic                   fire;
  logic                   in_take;
  dcd_pkg::cfg_t          cfg_regs;
  logic [SAMPLE_BITS-1:0] noise_floor;
  dcd_pkg::result_t       step_res;

  // held beat advances when the result register is free or being drained
  assign fire        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.operation <= in_ch.operation;
      in_item_r.sample_a  <= in_ch.sample_a;
      in_item_r.sample_b  <= in_ch.sample_b;
      in_item_r.sample_c  <= in_ch.sample_c;
      in_item_r.sample_d  <= in_ch.sample_d;
    end
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  dcd_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .regs  (cfg_regs)
  );

  dcd_calib #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_calib (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .noise_floor (noise_floor)
  );

  dcd_detect #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_detect (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .cfg         (cfg_regs),
    .noise_floor (noise_floor),
    .result      (step_res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.double_clap = out_res_r.double_clap;
  assign out_ch.phase       = out_res_r.phase;
  assign out_ch.level       = out_res_r.level;

endmodule
